>>> src/dtpc_pkg.sv
`timescale 1ns / 1ps

package dtpc_pkg;

  localparam logic [1:0] FUNC_ADVANCE = 2'd0;
  localparam logic [1:0] FUNC_WR0     = 2'd1;
  localparam logic [1:0] FUNC_WR1     = 2'd2;

  localparam logic [1:0] MODE_RELOAD  = 2'd0;
  localparam logic [1:0] MODE_INDEP   = 2'd1;
  localparam logic [1:0] MODE_WIDE    = 2'd2;
  localparam logic [1:0] MODE_CASCADE = 2'd3;

  localparam logic [1:0] REG_CTRL     = 2'd0;
  localparam logic [1:0] REG_T0_EN    = 2'd1;
  localparam logic [1:0] REG_T1_EN    = 2'd2;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned SHIFT_W = 4;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SHIFT_W-1:0] shift_t;

endpackage

>>> src/dtpc_prescaler.sv
`timescale 1ns / 1ps

module dtpc_prescaler import dtpc_pkg::*; #(
  parameter int unsigned CYCLE_FIELD_WIDTH = 8,
  parameter int unsigned TOT_W = 9
) (
  input  cnt_t                         acc_i,
  input  logic [CYCLE_FIELD_WIDTH-1:0] cycles_i,
  input  shift_t                       shift_i,
  output logic [TOT_W-1:0]             periods_o,
  output cnt_t                         rem_o
);

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] mask;

  assign total     = TOT_W'(acc_i) + TOT_W'(cycles_i);
  assign mask      = (TOT_W'(1) << shift_i) - TOT_W'(1);
  assign periods_o = total >> shift_i;
  assign rem_o     = cnt_t'(total & mask);

endmodule

>>> src/dual_timer_prescaled_cascade_top.sv
`timescale 1ns / 1ps
// An accepted beat's result is registered and offered in the next cycle.
// Throughput: one beat per cycle while in_stall_o is low; counts and prescalers
// update in the accept cycle. The result register frees the input whenever it is
// empty or being taken. Reset (async, rst_ni low): counts, prescalers and config
// registers clear, output valid drops.

module dual_timer_prescaled_cascade_top import dtpc_pkg::*; #(
  parameter int unsigned CYCLE_FIELD_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [CYCLE_FIELD_WIDTH-1:0] elapsed_cycles_i,
  input  logic [7:0]                   write_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   timer0_count_o,
  output logic [7:0]                   timer1_count_o,
  output logic                         timer0_overflow_o,
  output logic                         timer1_overflow_o,
  output logic                         irq_request_o
);

  localparam int unsigned TOT_W   = ((CYCLE_FIELD_WIDTH > CNT_W) ? CYCLE_FIELD_WIDTH : CNT_W) + 1;
  localparam int unsigned SUM_W   = TOT_W + 1;
  localparam int unsigned CARRY_W = SUM_W - CNT_W;
  localparam int unsigned CSUM_W  = ((CARRY_W > CNT_W) ? CARRY_W : CNT_W) + 1;

  // config
  logic [7:0] ctrl_q;
  logic       t0_en_q, t1_en_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      t0_en_q <= 1'b0;
      t1_en_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CTRL:  ctrl_q  <= pwdata[7:0];
        REG_T0_EN: t0_en_q <= pwdata[0];
        REG_T1_EN: t1_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CTRL:  prdata = {24'd0, ctrl_q};
      REG_T0_EN: prdata = {31'd0, t0_en_q};
      REG_T1_EN: prdata = {31'd0, t1_en_q};
      default:   prdata = '0;
    endcase
  end

  // handshake
  logic out_valid_q;
  logic accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // state
  cnt_t count0_q, count0_d;
  cnt_t count1_q, count1_d;
  cnt_t acc0_q, acc0_d;
  cnt_t acc1_q, acc1_d;

  logic [1:0] mode;
  shift_t     shift0, shift1;
  logic [TOT_W-1:0] inc0, inc1;
  cnt_t       rem0, rem1;

  assign mode   = ctrl_q[7:6];
  assign shift0 = (mode == MODE_INDEP) ? shift_t'({2'b00, ctrl_q[5:4]}) + shift_t'(1)
                                       : shift_t'({1'b0, ctrl_q[5:3]}) + shift_t'(1);
  assign shift1 = shift_t'({1'b0, ctrl_q[3:2], 1'b0}) + shift_t'(2);

  dtpc_prescaler #(
    .CYCLE_FIELD_WIDTH(CYCLE_FIELD_WIDTH),
    .TOT_W            (TOT_W)
  ) u_pre0 (
    .acc_i    (acc0_q),
    .cycles_i (elapsed_cycles_i),
    .shift_i  (shift0),
    .periods_o(inc0),
    .rem_o    (rem0)
  );

  dtpc_prescaler #(
    .CYCLE_FIELD_WIDTH(CYCLE_FIELD_WIDTH),
    .TOT_W            (TOT_W)
  ) u_pre1 (
    .acc_i    (acc1_q),
    .cycles_i (elapsed_cycles_i),
    .shift_i  (shift1),
    .periods_o(inc1),
    .rem_o    (rem1)
  );

  logic [SUM_W-1:0]   sum0, sum1b;
  logic [CSUM_W-1:0]  sum1c;
  logic               ovf0;
  logic               f0, f1;

  assign sum0  = SUM_W'(count0_q) + SUM_W'(inc0);
  assign ovf0  = |sum0[SUM_W-1:CNT_W];
  assign sum1c = CSUM_W'(count1_q) + CSUM_W'(sum0[SUM_W-1:CNT_W]);
  assign sum1b = SUM_W'(count1_q) + SUM_W'(inc1);

  always_comb begin
    count0_d = count0_q;
    count1_d = count1_q;
    acc0_d   = acc0_q;
    acc1_d   = acc1_q;
    f0       = 1'b0;
    f1       = 1'b0;
    case (func_i)
      FUNC_WR0: count0_d = write_value_i;
      FUNC_WR1: count1_d = write_value_i;
      FUNC_ADVANCE: begin
        if (t0_en_q) begin
          acc0_d   = rem0;
          count0_d = sum0[CNT_W-1:0];
          case (mode)
            MODE_RELOAD: begin
              if (ovf0) begin
                f0       = t1_en_q;
                count0_d = sum0[CNT_W-1:0] + count1_q;
              end
            end
            MODE_INDEP: f0 = ovf0;
            MODE_WIDE: begin
              if (ovf0) begin
                f1       = |sum1c[CSUM_W-1:CNT_W];
                count1_d = sum1c[CNT_W-1:0];
              end
            end
            default: begin
              f0 = ovf0;
              if (ovf0 && t1_en_q) begin
                f1       = |sum1c[CSUM_W-1:CNT_W];
                count1_d = sum1c[CNT_W-1:0];
              end
            end
          endcase
        end
        if (t1_en_q && mode == MODE_INDEP) begin
          acc1_d   = rem1;
          f1       = |sum1b[SUM_W-1:CNT_W];
          count1_d = sum1b[CNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count0_q    <= '0;
      count1_q    <= '0;
      acc0_q      <= '0;
      acc1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count0_q <= count0_d;
        count1_q <= count1_d;
        acc0_q   <= acc0_d;
        acc1_q   <= acc1_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  cnt_t res0_q, res1_q;
  logic res_f0_q, res_f1_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res0_q   <= count0_d;
      res1_q   <= count1_d;
      res_f0_q <= f0;
      res_f1_q <= f1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign timer0_count_o    = res0_q;
  assign timer1_count_o    = res1_q;
  assign timer0_overflow_o = res_f0_q;
  assign timer1_overflow_o = res_f1_q;
  assign irq_request_o     = res_f0_q | res_f1_q;

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_write_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i != FUNC_ADVANCE |=> !timer0_overflow_o && !timer1_overflow_o)
    else $error("write or idle beat raised a flag");

  a_wr0_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && func_i == FUNC_WR0 |=> timer0_count_o == $past(write_value_i))
    else $error("timer0 write value lost");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count0_q) && $stable(count1_q) && $stable(acc0_q) && $stable(acc1_q))
    else $error("timer state moved without a beat");

endmodule
